// ----- rtl/button_event_text_reporter_core_defines.svh -----
// assertion macros shared by the button event text reporter rtl
// no dependencies; expects a clk and rst in the scope of each use
`ifndef BUTTON_EVENT_TEXT_REPORTER_CORE_DEFINES_SVH
`define BUTTON_EVENT_TEXT_REPORTER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define BETR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("betr assertion failed");

// next-cycle implication, off during reset
`define BETR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("betr assertion failed");

`endif

// ----- rtl/betr_pkg.sv -----
// shared types, constants and message text lookup for the button reporter
// no dependencies
`default_nettype none

package betr_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAP_BITS        = 14;
  localparam int EVENT_BITS      = 5;

  // buttons: 0, 3, 4, 5, 6, 10, 13
  localparam logic [MAP_BITS-1:0] BUTTON_MASK = 14'h2479;

  localparam logic [3:0] BTN_MODE  = 4'd0;
  localparam logic [3:0] BTN_LEFT  = 4'd3;
  localparam logic [3:0] BTN_RIGHT = 4'd4;
  localparam logic [3:0] BTN_UP    = 4'd5;
  localparam logic [3:0] BTN_DOWN  = 4'd6;
  localparam logic [3:0] BTN_FIRE  = 4'd10;
  localparam logic [3:0] BTN_USER  = 4'd13;

  // line end characters
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_LOAD,
    ST_EMIT
  } betr_state_t;

  typedef struct packed {
    logic sample_load;
    logic push;
    logic pop_read;
    logic pop_take;
    logic emit;
  } betr_cmd_t;

  typedef struct packed {
    logic change_zero;
    logic queue_empty;
    logic msg_active;
    logic out_free;
  } betr_stat_t;

  // returns {last, char} for character pos of "<name> <PRESSED|RELEASED>\r\n"
  function automatic logic [8:0] msg_char(input logic [3:0] btn, input logic rel,
                                          input logic [4:0] pos);
    logic [47:0] nm;
    logic [4:0]  nlen;
    logic [79:0] sfx;
    logic [4:0]  slen;
    logic [4:0]  k;
    logic [4:0]  idx;
    logic [7:0]  ch;
    logic        last;
    unique case (btn)
      BTN_MODE:  begin nm = {8'h00, "MODE "};  nlen = 5'd5; end
      BTN_LEFT:  begin nm = {8'h00, "LEFT "};  nlen = 5'd5; end
      BTN_RIGHT: begin nm = "RIGHT ";          nlen = 5'd6; end
      BTN_UP:    begin nm = {24'h0, "UP "};    nlen = 5'd3; end
      BTN_DOWN:  begin nm = {8'h00, "DOWN "};  nlen = 5'd5; end
      BTN_FIRE:  begin nm = {8'h00, "FIRE "};  nlen = 5'd5; end
      BTN_USER:  begin nm = {8'h00, "USER "};  nlen = 5'd5; end
      default:   begin nm = {16'h0, "ERR "};   nlen = 5'd4; end
    endcase
    if (rel) begin
      sfx  = {"RELEASED", CHAR_CR, CHAR_LF};
      slen = 5'd10;
    end else begin
      sfx  = {8'h00, "PRESSED", CHAR_CR, CHAR_LF};
      slen = 5'd9;
    end
    if (pos < nlen) begin
      k    = 5'd0;
      idx  = nlen - 5'd1 - pos;
      ch   = nm[{idx[2:0], 3'b000} +: 8];
      last = 1'b0;
    end else begin
      k    = pos - nlen;
      idx  = slen - 5'd1 - k;
      ch   = sfx[{idx[3:0], 3'b000} +: 8];
      last = (k == slen - 5'd1);
    end
    return {last, ch};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/button_event_text_reporter_core.sv -----
// top level of the button event text reporter
// depends on betr_pkg, betr_ctrl, betr_dp (which holds betr_ram)
//
//   channel  handshake            payload                    direction
//   in       in_valid / in_stall  kind, engaged_map          into block
//   out      out_valid/out_stall  tx_byte, end_of_message    out of block
//
// sequence: a sample is loaded, then its changed buttons are queued before
//   the next item is taken (one queue write per cycle, single ram write port)
// a transmit slot in a running message goes to emit, one that starts a new
//   message goes through read (registered queue ram read), load (event load)
//   and emit; emit waits for a free output register, an idle slot stays idle
// reset: rst is synchronous; map, queue pointers and message state clear at
//   once, queue entries are not cleared and need no clearing pass
// stalls: a character waits in the output register; a new item is taken
//   meanwhile, only the next character waits for the register to drain
`default_nettype none

module button_event_text_reporter_core
  import betr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                kind,
  input  wire logic [MAP_BITS-1:0] engaged_map,
  // output channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               tx_byte,
  output logic                     end_of_message
);

  // command and status between controller and datapath
  betr_cmd_t  cmd;
  betr_stat_t stat;

  // controller: sequences sample scan, queue pop and character emit
  betr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .kind    (kind),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  // datapath: stored map, event queue ram, message text and output register
  betr_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .engaged_map   (engaged_map),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tx_byte       (tx_byte),
    .end_of_message(end_of_message)
  );

endmodule

`default_nettype wire

// ----- rtl/betr_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module betr_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/betr_ctrl.sv -----
// controller state machine for the button reporter
// depends on betr_pkg
`default_nettype none

module betr_ctrl
  import betr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       kind,
  output logic            in_stall,
  input  wire betr_stat_t stat,
  output betr_cmd_t       cmd
);

  betr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (!kind) begin
            cmd.sample_load = 1'b1;
            state_next      = ST_SCAN;
          end else if (stat.msg_active) begin
            state_next = ST_EMIT;
          end else if (!stat.queue_empty) begin
            state_next = ST_READ;
          end
        end
      end
      ST_SCAN: begin
        if (stat.change_zero) begin
          state_next = ST_IDLE;
        end else begin
          cmd.push = 1'b1;
        end
      end
      ST_READ: begin
        cmd.pop_read = 1'b1;
        state_next   = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.pop_take = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/betr_dp.sv -----
// datapath: button map, event queue, message position and output register
// depends on betr_pkg, betr_ram and the assertion macro header
`default_nettype none
`include "button_event_text_reporter_core_defines.svh"

module betr_dp
  import betr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire betr_cmd_t           cmd,
  output betr_stat_t               stat,
  input  wire logic [MAP_BITS-1:0] engaged_map,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               tx_byte,
  output logic                     end_of_message
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QW-1:0] LAST_PTR = QW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  logic [MAP_BITS-1:0]   prev_map;
  logic [MAP_BITS-1:0]   change;
  logic [QW-1:0]         head;
  logic [QW-1:0]         tail;
  logic [CW-1:0]         count;
  logic [3:0]            cur_btn;
  logic                  cur_rel;
  logic [4:0]            char_pos;
  logic                  msg_active;

  logic [3:0]            low_idx;
  logic [EVENT_BITS-1:0] push_event;
  logic [EVENT_BITS-1:0] rd_event;
  logic [8:0]            msg;
  logic [MAP_BITS-1:0]   masked_map;

  function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + QW'(1);
  endfunction

  assign masked_map = engaged_map & BUTTON_MASK;

  // lowest changed bit
  always_comb begin
    low_idx = 4'd0;
    for (int i = MAP_BITS - 1; i >= 0; i--) begin
      if (change[i]) begin
        low_idx = 4'(i);
      end
    end
  end

  // released flag is the old level, i.e. the inverse of the stored new level
  assign push_event = {low_idx, ~prev_map[low_idx]};

  assign msg = msg_char(cur_btn, cur_rel, char_pos);

  assign stat.change_zero = (change == '0);
  assign stat.queue_empty = (count == '0);
  assign stat.msg_active  = msg_active;
  assign stat.out_free    = !out_valid || !out_stall;

  betr_ram #(
    .WIDTH(EVENT_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(tail),
    .wdata(push_event),
    .re   (cmd.pop_read),
    .raddr(head),
    .rdata(rd_event)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_map   <= '0;
      change     <= '0;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      cur_btn    <= 4'd0;
      cur_rel    <= 1'b0;
      char_pos   <= 5'd0;
      msg_active <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.sample_load) begin
        change   <= masked_map ^ prev_map;
        prev_map <= masked_map;
      end
      if (cmd.push) begin
        change <= change & (change - MAP_BITS'(1));
        tail   <= ptr_inc(tail);
        if (count == FULL_CNT) begin
          head <= ptr_inc(head);
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.pop_take) begin
        cur_btn    <= rd_event[EVENT_BITS-1:1];
        cur_rel    <= rd_event[0];
        char_pos   <= 5'd0;
        msg_active <= 1'b1;
        head       <= ptr_inc(head);
        count      <= count - CW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (msg[8]) begin
          msg_active <= 1'b0;
          char_pos   <= 5'd0;
        end else begin
          char_pos <= char_pos + 5'd1;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tx_byte        <= msg[7:0];
      end_of_message <= msg[8];
    end
  end

  `BETR_ASSERT_IMPL(a_count_bound, 1'b1, count <= FULL_CNT)
  `BETR_ASSERT_IMPL(a_pop_nonempty, cmd.pop_take, count != '0 && !msg_active)
  `BETR_ASSERT_IMPL(a_emit_free, cmd.emit, (!out_valid || !out_stall) && msg_active)
  `BETR_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid)

endmodule

`default_nettype wire

// ----- test/button_event_text_reporter_core_tb.sv -----
// self-checking testbench for button_event_text_reporter_core
// depends on betr_pkg and the rtl of the core; predicts every report character
// in the testbench itself and checks each one against the output channel
`default_nettype none

module button_event_text_reporter_core_tb
  import betr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int QUIET_TAIL    = 150;     // last items run with no idling
  localparam int DRAIN_CYCLES  = 60;      // settle time after the last character
  localparam int CYCLE_LIMIT   = 400000;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_SLOT   = 1'b1;

  typedef struct {
    logic                kind;
    logic [MAP_BITS-1:0] map;
    bit                  hold;   // wait until every pending character has arrived
  } report_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eom;
  } tx_char_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                kind = KIND_SAMPLE;
  logic [MAP_BITS-1:0] engaged_map = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          tx_byte;
  logic                end_of_message;

  report_item_t pending_items[$];
  tx_char_t     expected_chars[$];

  int errors      = 0;
  int cycle_count = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  bit quiet_phase = 1'b0;

  // predictor state, mirrors the block
  logic [MAP_BITS-1:0]   prev_map   = '0;
  logic [EVENT_BITS-1:0] event_ring [DEPTH];
  int                    ring_head  = 0;
  int                    ring_tail  = 0;
  int                    ring_count = 0;
  logic [3:0]            msg_button = '0;
  logic                  msg_released = 1'b0;
  int                    msg_pos    = 0;
  bit                    msg_active = 1'b0;

  button_event_text_reporter_core #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .engaged_map    (engaged_map),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .tx_byte        (tx_byte),
    .end_of_message (end_of_message)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // name part of a report line, trailing space included
  function automatic string button_label(input logic [3:0] btn);
    case (btn)
      BTN_MODE:  return "MODE ";
      BTN_LEFT:  return "LEFT ";
      BTN_RIGHT: return "RIGHT ";
      BTN_UP:    return "UP ";
      BTN_DOWN:  return "DOWN ";
      BTN_FIRE:  return "FIRE ";
      BTN_USER:  return "USER ";
      default:   return "ERR ";
    endcase
  endfunction

  // event ring: a push onto a full ring drops the oldest event
  task automatic push_event(input logic [EVENT_BITS-1:0] ev);
    event_ring[ring_tail] = ev;
    ring_tail = (ring_tail + 1) % DEPTH;
    if (ring_count >= DEPTH) begin
      ring_head = (ring_head + 1) % DEPTH;
    end else begin
      ring_count++;
    end
  endtask

  // works out the character, if any, that one accepted item produces
  task automatic predict_report(input logic k, input logic [MAP_BITS-1:0] m);
    logic [MAP_BITS-1:0]   now_map;
    logic [MAP_BITS-1:0]   changed;
    logic [EVENT_BITS-1:0] ev;
    string                 text;
    int                    p;
    tx_char_t              c;
    if (k == KIND_SAMPLE) begin
      // bits outside the button mask never count
      now_map = m & BUTTON_MASK;
      changed = now_map ^ prev_map;
      for (int i = 0; i < MAP_BITS; i++) begin
        if (changed[i]) begin
          push_event({i[3:0], prev_map[i]});
        end
      end
      prev_map = now_map;
      return;
    end
    if (!msg_active) begin
      // idle slot: nothing to say
      if (ring_count == 0) begin
        return;
      end
      ev = event_ring[ring_head];
      ring_head = (ring_head + 1) % DEPTH;
      ring_count--;
      msg_button   = ev[4:1];
      msg_released = ev[0];
      msg_pos      = 0;
      msg_active   = 1'b1;
    end
    // state word ends with carriage return and line feed
    text = {button_label(msg_button), msg_released ? "RELEASED\015\012" : "PRESSED\015\012"};
    p = msg_pos;
    if (p >= text.len()) begin
      p = text.len() - 1;
    end
    c.ch = text[p];
    if (p + 1 >= text.len()) begin
      c.eom      = 1'b1;
      msg_active = 1'b0;
      msg_pos    = 0;
    end else begin
      c.eom   = 1'b0;
      msg_pos = p + 1;
    end
    expected_chars.push_back(c);
  endtask

  task automatic add_item(input logic k, input logic [MAP_BITS-1:0] m, input bit hold);
    report_item_t it;
    it.kind = k;
    it.map  = m;
    it.hold = hold;
    pending_items.push_back(it);
  endtask

  // driver: presents queued items, holds the payload while stalled
  always @(posedge clk) begin
    logic         nxt_valid;
    report_item_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        predict_report(kind, engaged_map);
        nxt_valid = 1'b0;
      end
      quiet_phase = (pending_items.size() < QUIET_TAIL);
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].hold && expected_chars.size() != 0)) begin
          item = pending_items.pop_front();
          kind        <= item.kind;
          engaged_map <= item.map;
          nxt_valid = 1'b1;
          // idle burst after this item, none near the end
          if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 18);
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // monitor: checks each accepted character, stalls in random bursts
  always @(posedge clk) begin
    tx_char_t want;
    logic     nxt_stall;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t unexpected character: expected none, got byte %h eom %b",
                   $time, tx_byte, end_of_message);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (tx_byte !== want.ch) begin
            $display("%0t tx_byte mismatch: expected %h, got %h", $time, want.ch, tx_byte);
            errors++;
          end
          if (end_of_message !== want.eom) begin
            $display("%0t end_of_message mismatch: expected %b, got %b",
                     $time, want.eom, end_of_message);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        nxt_stall = 1'b1;
      end else begin
        nxt_stall = 1'b0;
      end
      out_stall <= nxt_stall;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t run did not finish", $time);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int sel;
    int n;
    // idle slot with an empty queue gives nothing
    add_item(KIND_SLOT, 14'h3FFF, 1'b0);
    // every bit set, masked bits included: seven presses
    add_item(KIND_SAMPLE, 14'h3FFF, 1'b0);
    // a sample gives no character; drain the first line, mode pressed
    repeat (14) add_item(KIND_SLOT, 14'h0000, 1'b0);
    // all released: seven more events
    add_item(KIND_SAMPLE, 14'h0000, 1'b0);
    // press again: the queue fills and overwrites its oldest events
    add_item(KIND_SAMPLE, 14'h3FFF, 1'b0);
    // only the masked bits set, which reads as all released
    add_item(KIND_SAMPLE, 14'h3FFF & ~BUTTON_MASK, 1'b0);
    // hold off until every character so far has come out
    add_item(KIND_SLOT, 14'h1555, 1'b1);

    while (pending_items.size() < RANDOM_ITEMS + 25) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        // sample followed by slots that read most of its lines out
        add_item(KIND_SAMPLE, MAP_BITS'($urandom), $urandom_range(0, 39) == 0);
        n = $urandom_range(5, 80);
        repeat (n) add_item(KIND_SLOT, MAP_BITS'($urandom), 1'b0);
      end else if (sel < 8) begin
        // back to back samples pile events up and may overflow the queue
        n = $urandom_range(2, 6);
        repeat (n) add_item(KIND_SAMPLE, MAP_BITS'($urandom), 1'b0);
      end else begin
        add_item(1'($urandom_range(0, 1)), MAP_BITS'($urandom), 1'b0);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
